>>> rtl/bbq_pkg.sv
// ----------------------------------------------------------------------------
// Biquad filter package
// Fixed-point widths, register indexes, operand codes and the microprogram
// of the second-order direct form II filter sequencer.
// ----------------------------------------------------------------------------
package bbq_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int COEF_BITS     = 32;
  localparam int STATE_BITS    = 48;
  localparam int GAIN_BITS     = 40;
  localparam int COEF_FRAC     = 28;
  localparam int STATE_FRAC    = 24;
  // Wide operands are split into a low part of this many bits and a high part.
  localparam int SPLIT_BITS    = 24;
  localparam int MUL_A_BITS    = 32;
  localparam int MUL_B_BITS    = SPLIT_BITS + 1;
  localparam int PROD_BITS     = MUL_A_BITS + MUL_B_BITS;
  localparam int ACC_BITS      = 82;
  localparam int STEP_BITS     = 5;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 40;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_BYPASS = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_B0     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_B1     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_B2     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_A1     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_A2     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN   = 3'd6;

  // Multiplier operand A select.
  localparam logic [2:0] A_X  = 3'd0;
  localparam logic [2:0] A_B0 = 3'd1;
  localparam logic [2:0] A_B1 = 3'd2;
  localparam logic [2:0] A_B2 = 3'd3;
  localparam logic [2:0] A_A1 = 3'd4;
  localparam logic [2:0] A_A2 = 3'd5;

  // Multiplier operand B select.
  localparam logic [2:0] B_GLO  = 3'd0;
  localparam logic [2:0] B_GHI  = 3'd1;
  localparam logic [2:0] B_D1LO = 3'd2;
  localparam logic [2:0] B_D1HI = 3'd3;
  localparam logic [2:0] B_D2LO = 3'd4;
  localparam logic [2:0] B_D2HI = 3'd5;
  localparam logic [2:0] B_WLO  = 3'd6;
  localparam logic [2:0] B_WHI  = 3'd7;

  // Jump conditions.
  localparam logic [1:0] J_NONE   = 2'd0;
  localparam logic [1:0] J_NO_PRE = 2'd1;
  localparam logic [1:0] J_BYPASS = 2'd2;

  // Named steps of the program.
  localparam logic [STEP_BITS-1:0] STEP_PRE_COMMIT = 5'd4;
  localparam logic [STEP_BITS-1:0] STEP_Y_COMMIT   = 5'd18;

  typedef struct packed {
    logic                 mul_en;
    logic [2:0]           a_sel;
    logic [2:0]           b_sel;
    logic                 acc_clr;
    logic                 acc_hi;
    logic                 acc_neg;
    logic                 load_x;
    logic                 do_pre;
    logic                 do_w;
    logic                 do_y;
    logic [1:0]           jump;
    logic [STEP_BITS-1:0] target;
  } ucode_t;

  function automatic ucode_t uop(input logic [2:0] a, input logic [2:0] b,
                                 input logic clr, input logic hi, input logic neg);
    ucode_t u;
    u         = '0;
    u.mul_en  = 1'b1;
    u.a_sel   = a;
    u.b_sel   = b;
    u.acc_clr = clr;
    u.acc_hi  = hi;
    u.acc_neg = neg;
    return u;
  endfunction

  // A product issued in one step reaches the accumulator at the end of the
  // next step, so each commit step sits two steps after the last product.
  function automatic ucode_t ucode_rom(input logic [STEP_BITS-1:0] step);
    ucode_t u;
    u = '0;
    case (step)
      5'd0: begin
        u.jump   = J_NO_PRE;
        u.target = STEP_PRE_COMMIT;
      end
      5'd1:  u = uop(A_X, B_GLO, 1'b1, 1'b0, 1'b0);
      5'd2:  u = uop(A_X, B_GHI, 1'b0, 1'b1, 1'b0);
      5'd4: begin
        u.do_pre = 1'b1;
        u.jump   = J_BYPASS;
        u.target = STEP_Y_COMMIT;
      end
      5'd5: begin
        u        = uop(A_A1, B_D1LO, 1'b0, 1'b0, 1'b1);
        u.load_x = 1'b1;
      end
      5'd6:  u = uop(A_A1, B_D1HI, 1'b0, 1'b1, 1'b1);
      5'd7:  u = uop(A_A2, B_D2LO, 1'b0, 1'b0, 1'b1);
      5'd8:  u = uop(A_A2, B_D2HI, 1'b0, 1'b1, 1'b1);
      5'd10: u.do_w = 1'b1;
      5'd11: u = uop(A_B0, B_WLO, 1'b1, 1'b0, 1'b0);
      5'd12: u = uop(A_B0, B_WHI, 1'b0, 1'b1, 1'b0);
      5'd13: u = uop(A_B1, B_D1LO, 1'b0, 1'b0, 1'b0);
      5'd14: u = uop(A_B1, B_D1HI, 1'b0, 1'b1, 1'b0);
      5'd15: u = uop(A_B2, B_D2LO, 1'b0, 1'b0, 1'b0);
      5'd16: u = uop(A_B2, B_D2HI, 1'b0, 1'b1, 1'b0);
      5'd18: u.do_y = 1'b1;
      default: u = '0;
    endcase
    return u;
  endfunction

endpackage

>>> rtl/butterworth_biquad_filter.sv
// ----------------------------------------------------------------------------
// Butterworth biquad filter
// Second-order low-pass IIR in direct form II with software-loaded Q4.28
// coefficients, Q24.24 delay state and 24-bit samples, run by a microprogram.
// ----------------------------------------------------------------------------
// Usage: an input item (req_type, sample_in) is taken on in_valid/in_ready and
// one result item (sample_out, saturated) is given on out_valid/out_ready.
// Coefficients and the preload gain are written through cfg_we/cfg_index/
// cfg_data while the block is idle; a coefficient write clears both delays.
// The block works on one item at a time. A single 32x25 multiplier with a
// registered product is shared by all products: each 48-bit state value is
// split into two halves, so a filtered sample takes ten multiplier steps.
// A preload adds its own steps before the filter steps, and bypass skips the
// filter steps. in_ready is high again in the cycle out_valid rises, so a new
// item can be taken while the previous result still waits in the output
// register. If the receiver stalls and a new result is ready, the sequencer
// holds on its last step until the output register is free.
// Reset sets bypass, clears coefficients, gain and delays, and empties the
// output register.
// ----------------------------------------------------------------------------
module butterworth_biquad_filter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bbq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [bbq_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 req_type,
  input  logic signed [bbq_pkg::SAMPLE_BITS-1:0] sample_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [bbq_pkg::SAMPLE_BITS-1:0] sample_out,
  output logic                                 saturated
);

  localparam int SW  = bbq_pkg::SAMPLE_BITS;
  localparam int CW  = bbq_pkg::COEF_BITS;
  localparam int DW  = bbq_pkg::STATE_BITS;
  localparam int GW  = bbq_pkg::GAIN_BITS;
  localparam int HW  = bbq_pkg::SPLIT_BITS;
  localparam int AW  = bbq_pkg::MUL_A_BITS;
  localparam int BW  = bbq_pkg::MUL_B_BITS;
  localparam int PW  = bbq_pkg::PROD_BITS;
  localparam int XW  = bbq_pkg::ACC_BITS;
  localparam int STW = bbq_pkg::STEP_BITS;
  localparam int W_SHIFT = bbq_pkg::COEF_FRAC;
  localparam int Y_SHIFT = bbq_pkg::COEF_FRAC + bbq_pkg::STATE_FRAC;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam logic signed [XW-1:0] W_HALF = XW'(1) <<< (W_SHIFT - 1);
  localparam logic signed [XW-1:0] Y_HALF = XW'(1) <<< (Y_SHIFT - 1);
  localparam logic signed [DW-1:0] D_MAX  = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] D_MIN  = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [SW-1:0] S_MAX  = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN  = {1'b1, {(SW-1){1'b0}}};

  // True when v fits in a signed value of the given width.
  function automatic logic fits(input logic signed [XW-1:0] v, input int bits);
    logic signed [XW-1:0] t;
    t = v >>> (bits - 1);
    return (t == '0) || (&t);
  endfunction

  // Configuration registers.
  logic                 bypass;
  logic signed [CW-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic [GW-1:0]        reset_gain;

  // Filter state and item registers.
  logic signed [DW-1:0] delay_first, delay_second, w_reg;
  logic                 req;
  logic signed [SW-1:0] x;
  logic                 clip;

  // Sequencer.
  logic                 state;
  logic [STW-1:0]       step, step_next;
  bbq_pkg::ucode_t      uw;
  logic                 jump_taken, pre_fire, w_fire, y_fire;

  // Datapath.
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic                 prod_en, prod_clr, prod_hi, prod_neg;
  logic signed [XW-1:0] acc, acc_base, term, acc_next;
  logic signed [XW-1:0] w_round, y_round;
  logic                 pre_fit, w_fit, y_fit;
  logic signed [DW-1:0] pre_sat, w_sat;
  logic signed [SW-1:0] y_sat;
  logic                 cfg_coef_wr;

  assign in_ready    = (state == ST_IDLE);
  assign cfg_coef_wr = cfg_we && (cfg_index == bbq_pkg::REG_B0 ||
                                  cfg_index == bbq_pkg::REG_B1 ||
                                  cfg_index == bbq_pkg::REG_B2 ||
                                  cfg_index == bbq_pkg::REG_A1 ||
                                  cfg_index == bbq_pkg::REG_A2);

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass     <= 1'b1;
      coef_b0    <= '0;
      coef_b1    <= '0;
      coef_b2    <= '0;
      coef_a1    <= '0;
      coef_a2    <= '0;
      reset_gain <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bbq_pkg::REG_BYPASS: bypass     <= cfg_data[0];
        bbq_pkg::REG_B0:     coef_b0    <= cfg_data[CW-1:0];
        bbq_pkg::REG_B1:     coef_b1    <= cfg_data[CW-1:0];
        bbq_pkg::REG_B2:     coef_b2    <= cfg_data[CW-1:0];
        bbq_pkg::REG_A1:     coef_a1    <= cfg_data[CW-1:0];
        bbq_pkg::REG_A2:     coef_a2    <= cfg_data[CW-1:0];
        bbq_pkg::REG_GAIN:   reset_gain <= cfg_data[GW-1:0];
        default: ;
      endcase
    end
  end

  // Control word and next step.
  always_comb begin
    uw         = bbq_pkg::ucode_rom(step);
    jump_taken = (uw.jump == bbq_pkg::J_NO_PRE && !req) ||
                 (uw.jump == bbq_pkg::J_BYPASS && bypass);
    step_next  = jump_taken ? uw.target : step + STW'(1);
    pre_fire   = (state == ST_RUN) && uw.do_pre && req;
    w_fire     = (state == ST_RUN) && uw.do_w;
    y_fire     = (state == ST_RUN) && uw.do_y && (!out_valid || out_ready);
  end

  // Operand selection. Low halves are unsigned, high halves carry the sign.
  always_comb begin
    case (uw.a_sel)
      bbq_pkg::A_X:  mul_a = AW'(x);
      bbq_pkg::A_B0: mul_a = AW'(coef_b0);
      bbq_pkg::A_B1: mul_a = AW'(coef_b1);
      bbq_pkg::A_B2: mul_a = AW'(coef_b2);
      bbq_pkg::A_A1: mul_a = AW'(coef_a1);
      bbq_pkg::A_A2: mul_a = AW'(coef_a2);
      default:       mul_a = '0;
    endcase
    case (uw.b_sel)
      bbq_pkg::B_GLO:  mul_b = {1'b0, reset_gain[HW-1:0]};
      bbq_pkg::B_GHI:  mul_b = BW'(reset_gain[GW-1:HW]);
      bbq_pkg::B_D1LO: mul_b = {1'b0, delay_first[HW-1:0]};
      bbq_pkg::B_D1HI: mul_b = {delay_first[DW-1], delay_first[DW-1:HW]};
      bbq_pkg::B_D2LO: mul_b = {1'b0, delay_second[HW-1:0]};
      bbq_pkg::B_D2HI: mul_b = {delay_second[DW-1], delay_second[DW-1:HW]};
      bbq_pkg::B_WLO:  mul_b = {1'b0, w_reg[HW-1:0]};
      bbq_pkg::B_WHI:  mul_b = {w_reg[DW-1], w_reg[DW-1:HW]};
      default:         mul_b = '0;
    endcase
  end

  // Accumulate, round and saturate.
  always_comb begin
    term     = prod_hi ? (XW'(prod) <<< HW) : XW'(prod);
    acc_base = prod_clr ? '0 : acc;
    acc_next = prod_neg ? (acc_base - term) : (acc_base + term);
    pre_fit  = fits(acc, DW);
    pre_sat  = pre_fit ? acc[DW-1:0] : (acc[XW-1] ? D_MIN : D_MAX);
    w_round  = (acc + W_HALF) >>> W_SHIFT;
    w_fit    = fits(w_round, DW);
    w_sat    = w_fit ? w_round[DW-1:0] : (w_round[XW-1] ? D_MIN : D_MAX);
    y_round  = (acc + Y_HALF) >>> Y_SHIFT;
    y_fit    = fits(y_round, SW);
    y_sat    = y_fit ? y_round[SW-1:0] : (y_round[XW-1] ? S_MIN : S_MAX);
  end

  // Multiplier stage: the accumulate controls travel with the product.
  always_ff @(posedge clk) begin
    prod     <= mul_a * mul_b;
    prod_clr <= uw.acc_clr;
    prod_hi  <= uw.acc_hi;
    prod_neg <= uw.acc_neg;
    if (state == ST_RUN && uw.load_x) begin
      acc <= XW'(x) <<< Y_SHIFT;
    end else if (prod_en) begin
      acc <= acc_next;
    end
    if (w_fire) begin
      w_reg <= w_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_first  <= '0;
      delay_second <= '0;
    end else if (cfg_coef_wr) begin
      delay_first  <= '0;
      delay_second <= '0;
    end else if (pre_fire) begin
      delay_first  <= pre_sat;
      delay_second <= pre_sat;
    end else if (y_fire && !bypass) begin
      delay_second <= delay_first;
      delay_first  <= w_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      prod_en   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      prod_en <= (state == ST_RUN) && uw.mul_en;
      // A new result may only load when the output register is empty or
      // being emptied in this cycle.
      if (y_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_RUN;
            step  <= '0;
          end
        end
        ST_RUN: begin
          if (uw.do_y) begin
            if (y_fire) begin
              state <= ST_IDLE;
            end
          end else begin
            step <= step_next;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req  <= req_type;
      x    <= sample_in;
      clip <= 1'b0;
    end else if (pre_fire) begin
      clip <= clip | !pre_fit;
    end else if (w_fire) begin
      clip <= clip | !w_fit;
    end
    if (y_fire) begin
      sample_out <= bypass ? x : y_sat;
      saturated  <= bypass ? clip : (clip | !y_fit);
    end
  end

endmodule

>>> rtl/bbq_checker.sv
// ----------------------------------------------------------------------------
// Biquad filter port checker
// Watches the handshake ports of the filter over time.
// ----------------------------------------------------------------------------
module bbq_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [bbq_pkg::SAMPLE_BITS-1:0] sample_out,
  input logic                                 saturated
);

  // After reset the block is idle with an empty output register.
  a_reset_idle: assert property (@(posedge clk) rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(saturated))
    else $error("stalled result changed");

  // An accepted item keeps the block busy, so in_ready stays low after acceptance.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input taken again too early");

  // No result can appear in the cycle right after an item is accepted.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind butterworth_biquad_filter bbq_checker u_bbq_checker (.*);

>>> bench/biquad_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad filter checker
// Watches the register writes and both item channels of the biquad filter.
// It keeps its own copy of the coefficients and the delay state, computes the
// exact filtered sample for every item taken in, and compares each result
// item field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module biquad_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [bbq_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [bbq_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic                                   req_type,
  input  logic signed [bbq_pkg::SAMPLE_BITS-1:0] sample_in,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic signed [bbq_pkg::SAMPLE_BITS-1:0] sample_out,
  input  logic                                   saturated,
  output int                                     mismatch_count,
  output int                                     outstanding
);

  localparam int SW      = bbq_pkg::SAMPLE_BITS;
  localparam int CW      = bbq_pkg::COEF_BITS;
  localparam int DW      = bbq_pkg::STATE_BITS;
  localparam int GW      = bbq_pkg::GAIN_BITS;
  localparam int W_SHIFT = bbq_pkg::COEF_FRAC;
  localparam int Y_SHIFT = bbq_pkg::COEF_FRAC + bbq_pkg::STATE_FRAC;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [SW-1:0] sample;
    logic                 clip;
  } filter_out_t;

  localparam wide_t W_ROUND = 128'sd1 <<< (W_SHIFT - 1);
  localparam wide_t Y_ROUND = 128'sd1 <<< (Y_SHIFT - 1);

  filter_out_t pending_outputs[$];

  logic                 bypass_on;
  logic signed [CW-1:0] b0, b1, b2, a1, a2;
  logic [GW-1:0]        preload_gain;
  logic signed [DW-1:0] delay1, delay2;

  function automatic wide_t clamp(input wide_t v, input int bits, inout logic clip);
    wide_t top_v;
    wide_t bot_v;
    top_v = (128'sd1 <<< (bits - 1)) - 128'sd1;
    bot_v = -(128'sd1 <<< (bits - 1));
    if (v > top_v) begin
      clip = 1'b1;
      return top_v;
    end
    if (v < bot_v) begin
      clip = 1'b1;
      return bot_v;
    end
    return v;
  endfunction

  // Exact direct form II step; every sum is kept at full width and rounded once.
  function automatic filter_out_t predict_sample(input logic preload,
                                                 input logic signed [SW-1:0] x);
    wide_t       xw;
    wide_t       acc;
    wide_t       w_new;
    wide_t       y_new;
    logic        clip;
    filter_out_t r;
    clip = 1'b0;
    xw   = x;
    if (preload) begin
      acc    = clamp(xw * $signed({88'd0, preload_gain}), DW, clip);
      delay1 = acc[DW-1:0];
      delay2 = acc[DW-1:0];
    end
    if (bypass_on) begin
      r.sample = x;
      r.clip   = clip;
      return r;
    end
    acc = (xw <<< Y_SHIFT) - wide_t'(a1) * wide_t'(delay1)
          - wide_t'(a2) * wide_t'(delay2);
    w_new = clamp((acc + W_ROUND) >>> W_SHIFT, DW, clip);
    acc = wide_t'(b0) * w_new + wide_t'(b1) * wide_t'(delay1)
          + wide_t'(b2) * wide_t'(delay2);
    y_new = clamp((acc + Y_ROUND) >>> Y_SHIFT, SW, clip);
    delay2 = delay1;
    delay1 = w_new[DW-1:0];
    r.sample = y_new[SW-1:0];
    r.clip   = clip;
    return r;
  endfunction

  always @(posedge clk) begin
    filter_out_t want;
    if (rst) begin
      bypass_on    = 1'b1;
      b0           = '0;
      b1           = '0;
      b2           = '0;
      a1           = '0;
      a2           = '0;
      preload_gain = '0;
      delay1       = '0;
      delay2       = '0;
      pending_outputs.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bbq_pkg::REG_BYPASS: bypass_on = cfg_data[0];
          bbq_pkg::REG_B0: begin b0 = cfg_data[CW-1:0]; delay1 = '0; delay2 = '0; end
          bbq_pkg::REG_B1: begin b1 = cfg_data[CW-1:0]; delay1 = '0; delay2 = '0; end
          bbq_pkg::REG_B2: begin b2 = cfg_data[CW-1:0]; delay1 = '0; delay2 = '0; end
          bbq_pkg::REG_A1: begin a1 = cfg_data[CW-1:0]; delay1 = '0; delay2 = '0; end
          bbq_pkg::REG_A2: begin a2 = cfg_data[CW-1:0]; delay1 = '0; delay2 = '0; end
          bbq_pkg::REG_GAIN: preload_gain = cfg_data[GW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pending_outputs.push_back(predict_sample(req_type, sample_in));
      if (out_valid && out_ready) begin
        if (pending_outputs.size() == 0) begin
          $error("result item with none expected: sample_out %0d, saturated %0b",
                 sample_out, saturated);
          mismatch_count++;
        end else begin
          want = pending_outputs.pop_front();
          if (sample_out !== want.sample) begin
            $error("sample_out mismatch: expected %0d, actual %0d", want.sample, sample_out);
            mismatch_count++;
          end
          if (saturated !== want.clip) begin
            $error("saturated mismatch: expected %0b, actual %0b", want.clip, saturated);
            mismatch_count++;
          end
        end
      end
    end
    outstanding = pending_outputs.size();
  end

endmodule

>>> bench/butterworth_biquad_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Butterworth biquad filter testbench
// Drives directed and random sample items through the filter under a series
// of coefficient settings, with random gaps on both channels and one long
// output stall. The checker predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module butterworth_biquad_filter_tb;

  localparam int SW  = bbq_pkg::SAMPLE_BITS;
  localparam int CIW = bbq_pkg::CFG_IDX_BITS;
  localparam int CDW = bbq_pkg::CFG_DATA_BITS;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 25;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 205;

  localparam logic [CIW-1:0] REG_NONE = 3'd7;

  // Butterworth low-pass at a quarter of the sample rate, Q4.28.
  localparam logic [CDW-1:0] BW_B0   = 40'd78622925;
  localparam logic [CDW-1:0] BW_B1   = 40'd157245850;
  localparam logic [CDW-1:0] BW_A1   = 40'd0;
  localparam logic [CDW-1:0] BW_A2   = 40'd46056247;
  localparam logic [CDW-1:0] BW_GAIN = 40'd14320285;

  localparam logic signed [SW-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SW-1:0] S_MIN = 24'sh800000;
  localparam logic [CDW-1:0] C_MAX = 40'h00_7FFF_FFFF;
  localparam logic [CDW-1:0] C_MIN = 40'hFF_8000_0000;
  localparam logic [CDW-1:0] ALL_ONES = 40'hFF_FFFF_FFFF;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CIW-1:0]       cfg_index = '0;
  logic [CDW-1:0]       cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 req_type = 1'b0;
  logic signed [SW-1:0] sample_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [SW-1:0] sample_out;
  logic                 saturated;

  int mismatch_count;
  int outstanding;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit idle_on = 1'b1;

  butterworth_biquad_filter u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .saturated  (saturated)
  );

  biquad_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .sample_in      (sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sample_out     (sample_out),
    .saturated      (saturated),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long stall on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idle_on && $urandom_range(0, 99) < 11);
      end
    end
  end

  task automatic send_item(input logic rt, input logic signed [SW-1:0] s);
    int gap;
    gap = (idle_on && $urandom_range(0, 99) < 11) ? $urandom_range(1, 6) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= rt;
    sample_in <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Lets every expected result come back before the next register write.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CIW-1:0] idx,
                           input logic [CDW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_filter(input logic [CDW-1:0] c_b0, c_b1, c_b2,
                              input logic [CDW-1:0] c_a1, c_a2, c_gain,
                              input logic byp);
    write_reg(bbq_pkg::REG_B0, c_b0);
    write_reg(bbq_pkg::REG_B1, c_b1);
    write_reg(bbq_pkg::REG_B2, c_b2);
    write_reg(bbq_pkg::REG_A1, c_a1);
    write_reg(bbq_pkg::REG_A2, c_a2);
    write_reg(bbq_pkg::REG_GAIN, c_gain);
    // Upper bits of the bypass word are junk that the block must drop.
    write_reg(bbq_pkg::REG_BYPASS, CDW'({$urandom, byp}));
    if ($urandom_range(0, 3) == 0)
      write_reg(REG_NONE, CDW'({$urandom, $urandom}));
  endtask

  function automatic logic [CDW-1:0] rand_word();
    return CDW'({$urandom, $urandom});
  endfunction

  function automatic logic [CDW-1:0] extreme_coef();
    return $urandom_range(0, 1) ? C_MAX : C_MIN;
  endfunction

  initial begin
    logic signed [SW-1:0] smp;
    logic [63:0]          gain;
    int                   base;
    int                   fb1;
    int                   fb2;

    smp = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Out of reset the block is in bypass with zero gain.
    send_item(1'b0, S_MAX);
    send_item(1'b0, S_MIN);
    send_item(1'b1, 24'sh123456);
    drain();

    // Full-scale gain: a preload in bypass clips on large samples.
    write_reg(bbq_pkg::REG_GAIN, ALL_ONES);
    write_reg(REG_NONE, ALL_ONES);
    send_item(1'b1, S_MAX);
    send_item(1'b1, S_MIN);
    send_item(1'b1, 24'sd0);
    send_item(1'b1, 24'sd1);
    send_item(1'b1, -24'sd1);
    drain();

    write_filter(BW_B0, BW_B1, BW_B0, BW_A1, BW_A2, BW_GAIN, 1'b0);
    send_item(1'b1, S_MAX);
    repeat (3) send_item(1'b0, S_MAX);
    send_item(1'b0, S_MIN);
    send_item(1'b0, 24'sd0);
    send_item(1'b0, -24'sd1);
    drain();

    // Bypass and gain writes leave the delays as they were.
    write_reg(bbq_pkg::REG_BYPASS, 40'd1);
    send_item(1'b0, 24'sd1000);
    drain();
    write_reg(bbq_pkg::REG_BYPASS, 40'd0);
    write_reg(bbq_pkg::REG_GAIN, 40'd12345);
    send_item(1'b0, 24'sd0);
    drain();

    // Largest coefficients drive both the state and the output into clipping.
    write_filter(C_MAX, C_MAX, C_MAX, C_MIN, C_MAX, ALL_ONES, 1'b0);
    repeat (3) send_item(1'b0, S_MAX);
    repeat (2) send_item(1'b0, S_MIN);
    send_item(1'b1, S_MIN);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == PHASES - 1) begin
        write_filter(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, '0, 1'b0);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            // Low-pass shape with random corner and damping.
            base = $urandom_range(1 << 20, 1 << 27);
            fb1  = int'($urandom_range(0, 1020000000)) - 510000000;
            fb2  = $urandom_range(0, 255000000);
            gain = (64'd1 << 52) / 64'(4 * base);
            write_filter(CDW'(base), CDW'(2 * base), CDW'(base), CDW'(fb1), CDW'(fb2),
                         gain[CDW-1:0], $urandom_range(0, 5) == 0);
          end
          6, 7, 8: begin
            write_filter(rand_word(), rand_word(), rand_word(), rand_word(),
                         rand_word(), rand_word(), $urandom_range(0, 5) == 0);
          end
          default: begin
            write_filter(extreme_coef(), extreme_coef(), extreme_coef(), extreme_coef(),
                         extreme_coef(), $urandom_range(0, 1) ? ALL_ONES : '0, 1'b0);
          end
        endcase
      end
      idle_on = (phase != 3);
      if (phase == 5)
        hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 9))
          0:       smp = S_MAX;
          1:       smp = S_MIN;
          2:       smp = SW'(int'($urandom_range(0, 64)) - 32);
          3:       ; // repeat the last sample to build a step
          default: smp = SW'($urandom);
        endcase
        send_item($urandom_range(0, 99) < 8, smp);
      end
      idle_on = 1'b1;
      drain();
    end

    if (mismatch_count == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
